### src/i2cmbc_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbc_pkg - shared types for the I2C master byte controller
// Command and status codes, bus phase encoding and channel payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbc_pkg;

	// command codes on the request channel
	localparam logic [2:0] CMD_NONE      = 3'd0;
	localparam logic [2:0] CMD_START     = 3'd1;
	localparam logic [2:0] CMD_STOP      = 3'd2;
	localparam logic [2:0] CMD_WRITE     = 3'd3;
	localparam logic [2:0] CMD_READ_ACK  = 3'd4;
	localparam logic [2:0] CMD_READ_NACK = 3'd5;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd12;
	localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_NACK = 2'd1,
		STS_BUSY = 2'd2,
		STS_ERR  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ST_SDA1 = 4'd1,
		PH_ST_SCL1 = 4'd2,
		PH_ST_SDA0 = 4'd3,
		PH_ST_SCL0 = 4'd4,
		PH_SP_SDA0 = 4'd5,
		PH_SP_SCL1 = 4'd6,
		PH_SP_SDA1 = 4'd7,
		PH_WR_LOW  = 4'd8,
		PH_WR_HIGH = 4'd9,
		PH_RD_HIGH = 4'd10,
		PH_RD_LOW  = 4'd11,
		PH_AK_SDA  = 4'd12,
		PH_AK_SCL1 = 4'd13,
		PH_AK_SCL0 = 4'd14
	} phase_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       sda_in;
	} req_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic [1:0] status;
	} rsp_item_t;

endpackage

`default_nettype wire

### src/i2cmbc_stream_if.sv
// ----------------------------------------------------------------------------
// i2cmbc_stream_if - valid/ready channel
// Carries one payload per transfer; source drives valid and data, sink ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmbc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/i2c_master_byte_controller_core.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_controller_core - open-drain I2C master byte engine
// Start/stop/write/read+ack/read+nack bit sequencer, one bus tick per transfer.
// ----------------------------------------------------------------------------
// Result: each tick's result is registered into the output register in the cycle
//   after the tick is accepted on req.
// Throughput: one tick per cycle; req stays ready while the result register
//   is empty or being drained in the same cycle.
// Reset (arst_n low): bus idle, SCL driven low, SDA released, phase_ticks=12,
//   received byte and status cleared, output register empty.
`default_nettype none

module i2c_master_byte_controller_core
	import i2cmbc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	i2cmbc_stream_if.sink    req,
	i2cmbc_stream_if.source  rsp
);

	// ------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------
	logic [15:0] phase_ticks_q;
	phase_t      phase_q, phase_d;
	logic [2:0]  cmd_q, cmd_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_q, tick_d;
	status_t     status_q, status_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic [7:0]  rx_q, rx_d;

	logic        res_valid_q;
	rsp_item_t   res_data_q;

	// ------------------------------------------------------------------
	// per-tick decode
	// ------------------------------------------------------------------
	logic        accept;
	logic        cmd_ok;
	logic [15:0] limit;
	logic [15:0] tick_inc;
	logic        ph_end;
	logic        enter;
	logic        done;
	req_item_t   it;

	assign it = req.data;

	// output register frees up when empty or when drained this cycle
	assign req.ready = !res_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign cmd_ok   = it.cmd inside {[CMD_START:CMD_READ_NACK]};
	// zero phase length behaves as one tick
	assign limit    = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
	assign tick_inc = tick_q + 16'd1;
	assign ph_end   = (phase_q != PH_IDLE) && (tick_inc >= limit);

	// next bus phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (phase_q == PH_IDLE) begin
				if (cmd_ok) begin
					case (it.cmd)
						CMD_START: phase_d = PH_ST_SDA1;
						CMD_STOP:  phase_d = PH_SP_SDA0;
						CMD_WRITE: phase_d = PH_WR_LOW;
						default:   phase_d = PH_RD_HIGH;
					endcase
				end
			end else if (ph_end) begin
				case (phase_q)
					PH_ST_SDA1: phase_d = PH_ST_SCL1;
					// SDA held low by someone else: bus busy, abort
					PH_ST_SCL1: phase_d = it.sda_in ? PH_ST_SDA0 : PH_IDLE;
					PH_ST_SDA0: phase_d = PH_ST_SCL0;
					PH_SP_SDA0: phase_d = PH_SP_SCL1;
					PH_SP_SCL1: phase_d = PH_SP_SDA1;
					PH_WR_LOW:  phase_d = PH_WR_HIGH;
					// the clock of the ack bit, after all data bits, ends the write
					PH_WR_HIGH: phase_d = bit_q[3] ? PH_IDLE : PH_WR_LOW;
					PH_RD_HIGH: phase_d = PH_RD_LOW;
					PH_RD_LOW:  phase_d = ((bit_q + 4'd1) >= BITS_PER_BYTE) ?
						PH_AK_SDA : PH_RD_HIGH;
					PH_AK_SDA:  phase_d = PH_AK_SCL1;
					PH_AK_SCL1: phase_d = PH_AK_SCL0;
					default:    phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// every transition lands in a different phase, so a change marks an entry
	assign enter = accept && (phase_d != phase_q) && (phase_d != PH_IDLE);

	// datapath and line levels
	always_comb begin
		cmd_d    = cmd_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		tick_d   = tick_q;
		status_d = status_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		rx_d     = rx_q;
		done     = 1'b0;

		if (accept) begin
			if (phase_q == PH_IDLE) begin
				if (cmd_ok) begin
					cmd_d  = it.cmd;
					bit_d  = 4'd0;
					tick_d = 16'd0;
					if (it.cmd == CMD_WRITE) begin
						shift_d = it.tx_byte;
					end else if (it.cmd inside {CMD_READ_ACK, CMD_READ_NACK}) begin
						shift_d = 8'd0;
						sda_d   = 1'b1;
						scl_d   = 1'b0;
					end
				end
			end else begin
				tick_d = ph_end ? 16'd0 : tick_inc;
				if (ph_end) begin
					case (phase_q)
						PH_ST_SCL1: begin
							if (!it.sda_in) begin
								status_d = STS_BUSY;
								done     = 1'b1;
							end
						end
						PH_ST_SCL0: begin
							// SDA never went low: line stuck or contended
							status_d = it.sda_in ? STS_ERR : STS_OK;
							done     = 1'b1;
						end
						PH_SP_SDA1: begin
							status_d = STS_OK;
							done     = 1'b1;
						end
						PH_WR_HIGH: begin
							if (!bit_q[3]) begin
								shift_d = {shift_q[6:0], 1'b0};
								bit_d   = bit_q + 4'd1;
							end else begin
								scl_d    = 1'b0;
								sda_d    = 1'b1;
								status_d = it.sda_in ? STS_NACK : STS_OK;
								done     = 1'b1;
							end
						end
						PH_RD_HIGH: shift_d = {shift_q[6:0], it.sda_in};
						PH_RD_LOW:  bit_d   = bit_q + 4'd1;
						PH_AK_SCL0: begin
							if (cmd_q == CMD_READ_ACK) begin
								sda_d = 1'b1;
							end
							rx_d     = shift_q;
							status_d = STS_OK;
							done     = 1'b1;
						end
						default: ;
					endcase
				end
			end

			// line change that opens the new phase
			if (enter) begin
				case (phase_d)
					PH_ST_SDA1: sda_d = 1'b1;
					PH_ST_SCL1: scl_d = 1'b1;
					PH_ST_SDA0: sda_d = 1'b0;
					PH_ST_SCL0: scl_d = 1'b0;
					PH_SP_SDA0: sda_d = 1'b0;
					PH_SP_SCL1: scl_d = 1'b1;
					PH_SP_SDA1: sda_d = 1'b1;
					PH_WR_LOW: begin
						scl_d = 1'b0;
						sda_d = bit_d[3] ? 1'b1 : shift_d[7];
					end
					PH_WR_HIGH: scl_d = 1'b1;
					PH_RD_HIGH: scl_d = 1'b1;
					PH_RD_LOW:  scl_d = 1'b0;
					PH_AK_SDA:  sda_d = (cmd_d == CMD_READ_ACK) ? 1'b0 : 1'b1;
					PH_AK_SCL1: scl_d = 1'b1;
					PH_AK_SCL0: scl_d = 1'b0;
					default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			phase_q       <= PH_IDLE;
			cmd_q         <= CMD_NONE;
			bit_q         <= 4'd0;
			shift_q       <= 8'd0;
			tick_q        <= 16'd0;
			status_q      <= STS_OK;
			scl_q         <= 1'b0;
			sda_q         <= 1'b1;
			rx_q          <= 8'd0;
		end else begin
			if (cfg_we) begin
				phase_ticks_q <= cfg_wdata;
			end
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			tick_q   <= tick_d;
			status_q <= status_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			rx_q     <= rx_d;
		end
	end

	// result register: one result per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q.scl_out  <= scl_d;
			res_data_q.sda_out  <= sda_d;
			res_data_q.busy_res <= (phase_d != PH_IDLE);
			res_data_q.done_res <= done;
			res_data_q.rx_byte  <= rx_d;
			res_data_q.status   <= status_d;
		end
	end

	assign rsp.valid = res_valid_q;
	assign rsp.data  = res_data_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_idle_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == 16'd0))
		else $error("tick counter running while idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit index past byte length");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_data_q.done_res) |-> !res_data_q.busy_res)
		else $error("done reported while still busy");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted tick produced no result");

	a_busy_released: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done && (status_d == STS_BUSY)) |-> (scl_d && sda_d))
		else $error("bus busy abort left a line driven low");

endmodule

`default_nettype wire
